FILE: rtl/core/plra_pkg.sv
// shared types and codes for the power limit request arbiter
// no dependencies; used by plra_cell and power_limit_request_arbiter
package plra_pkg;

  localparam int REQUESTERS_DEF    = 16;
  localparam int CONTROL_TYPES_DEF = 4;
  localparam int NUM_LIMITS        = 5;
  localparam int LIMIT_W           = 32;

  // limit positions in a limit vector
  localparam int LIM_MAX_POWER  = 0;
  localparam int LIM_MIN_POWER  = 1;
  localparam int LIM_STEP       = 2;
  localparam int LIM_MAX_WINDOW = 3;
  localparam int LIM_MIN_WINDOW = 4;

  // item modes
  localparam logic [2:0] MODE_COMMIT = 3'd0;
  localparam logic [2:0] MODE_STAGE  = 3'd1;
  localparam logic [2:0] MODE_CLEAR  = 3'd2;
  localparam logic [2:0] MODE_QUERY  = 3'd3;
  localparam logic [2:0] MODE_REMOVE = 3'd4;
  localparam logic [2:0] MODE_LOCK   = 3'd5;

  typedef logic [NUM_LIMITS-1:0][LIMIT_W-1:0] limits_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic [3:0]            req;
    logic [1:0]            ct;
    limits_t               vals;
    logic [NUM_LIMITS-1:0] vmask;
    logic                  flag;
  } cmd_t;

  // overlay entry of the queried type as seen by every cell
  typedef struct packed {
    logic                  present;
    logic                  flag;
    logic [3:0]            req;
    limits_t               vals;
    logic [NUM_LIMITS-1:0] mask;
  } ovl_view_t;

  // partial arbitration result handed down the chain
  typedef struct packed {
    logic                  present;
    logic [NUM_LIMITS-1:0] mask;
    limits_t               vals;
  } token_t;

endpackage

FILE: rtl/core/plra_cell.sv
// one requester's cell: its entries, lock request and one chain stage
// depends on plra_pkg
module plra_cell #(
  parameter int R             = 0,
  parameter int CONTROL_TYPES = plra_pkg::CONTROL_TYPES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plra_pkg::cmd_t      cmd,
  input  logic                wr_en,
  input  plra_pkg::ovl_view_t ovl,
  input  plra_pkg::token_t    tok_in,
  output plra_pkg::token_t    tok_out,
  output logic                any_present,
  output logic                lock_req
);
  import plra_pkg::*;

  localparam int CIW = (CONTROL_TYPES > 1) ? $clog2(CONTROL_TYPES) : 1;

  limits_t                 val_mem   [CONTROL_TYPES];
  logic [NUM_LIMITS-1:0]   vmask_mem [CONTROL_TYPES];
  logic [CONTROL_TYPES-1:0] present_r, present_nxt;
  logic                    lock_r, lock_nxt;
  token_t                  tok_r, tok_nxt;

  logic [15:0]     ct_ext;
  logic [CIW-1:0]  idx;
  logic            ct_ok, hit, use_ovl, use_ent;
  limits_t         ev;
  logic [NUM_LIMITS-1:0] em;

  assign ct_ext  = 16'(cmd.ct);
  assign idx     = ct_ext[CIW-1:0];
  assign ct_ok   = 32'(cmd.ct) < CONTROL_TYPES;
  assign hit     = 32'(cmd.req) == R;
  assign use_ovl = ovl.flag && ovl.present && (32'(ovl.req) == R);
  assign use_ent = !use_ovl && ct_ok && present_r[idx];
  assign ev      = use_ovl ? ovl.vals : val_mem[idx];
  assign em      = use_ovl ? ovl.mask : vmask_mem[idx];

  always_comb begin
    tok_nxt = tok_in;
    if (use_ovl || use_ent) begin
      tok_nxt.present = 1'b1;
      for (int i = 0; i < NUM_LIMITS; i++) begin
        if (em[i]) begin
          if (tok_in.mask[i]) begin
            if (i == LIM_STEP || i == LIM_MIN_WINDOW) begin
              tok_nxt.vals[i] = (ev[i] > tok_in.vals[i]) ? ev[i] : tok_in.vals[i];
            end else begin
              tok_nxt.vals[i] = (ev[i] < tok_in.vals[i]) ? ev[i] : tok_in.vals[i];
            end
          end else begin
            tok_nxt.vals[i] = ev[i];
          end
          tok_nxt.mask[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    present_nxt = present_r;
    lock_nxt    = lock_r;
    if (wr_en && hit) begin
      if (cmd.mode == MODE_COMMIT && ct_ok) begin
        present_nxt[idx] = 1'b1;
      end else if (cmd.mode == MODE_REMOVE) begin
        present_nxt = '0;
        lock_nxt    = 1'b0;
      end else if (cmd.mode == MODE_LOCK) begin
        lock_nxt = cmd.flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      lock_r    <= 1'b0;
    end else begin
      present_r <= present_nxt;
      lock_r    <= lock_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (wr_en && hit && ct_ok && cmd.mode == MODE_COMMIT) begin
      val_mem[idx]   <= cmd.vals;
      vmask_mem[idx] <= cmd.vmask;
    end
  end

  assign tok_out     = tok_r;
  assign any_present = |present_r;
  assign lock_req    = lock_r;

endmodule

FILE: rtl/core/power_limit_request_arbiter.sv
// top level of the power limit request arbiter: control, overlay and cell row
// depends on plra_pkg and plra_cell
//
// Each requester owns one cell holding its entries for every control type and
// its lock request. Write words (commit, stage, clear stage, remove, lock)
// pass from acceptance through the execute state and then the finish state.
// A query sends a partial result down the row of cells, one cell per cycle,
// through the execute and walk states and then the finish state. One word is
// worked on at a time; a finished result waits in the output register while
// the next word is accepted, and a stalled output holds the finish step until
// the register frees up. Every word gives exactly one result word.
module power_limit_request_arbiter #(
  parameter int REQUESTERS    = plra_pkg::REQUESTERS_DEF,
  parameter int CONTROL_TYPES = plra_pkg::CONTROL_TYPES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // requester, control_type, max_power, min_power, power_step, max_window,
  // min_window, valid_mask, flag, zero fill
  input  logic [175:0] in_tdata,
  // mode
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_max_power, out_min_power, out_power_step, out_max_window,
  // out_min_window, out_valid_mask, type_present, any_request, lock_state,
  // lock_changed, zero fill
  output logic [175:0] out_tdata
);
  import plra_pkg::*;

  localparam int CIW = (CONTROL_TYPES > 1) ? $clog2(CONTROL_TYPES) : 1;
  localparam int CW  = $clog2(REQUESTERS + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  cmd_t   cmd_r;
  logic   lock_before_r;
  logic   out_tvalid_r;
  logic [175:0] out_tdata_r;

  // staged what-if overlay
  limits_t               ovl_vals_r [CONTROL_TYPES];
  logic [NUM_LIMITS-1:0] ovl_mask_r [CONTROL_TYPES];
  logic [CONTROL_TYPES-1:0] ovl_present_r;
  logic [3:0]            ovl_req_r;

  logic accept, wr_en, fin_load;
  cmd_t in_cmd;
  logic [15:0]    ct_ext;
  logic [CIW-1:0] idx;
  logic ct_ok, req_ok;
  ovl_view_t ovl;

  token_t tok [REQUESTERS+1];
  logic [REQUESTERS-1:0] any_vec, lock_vec;

  limits_t res;
  logic [NUM_LIMITS-1:0] res_mask;
  logic type_present, lock_changed;

  // unpack the input word
  assign in_cmd.mode  = in_tuser;
  assign in_cmd.req   = in_tdata[3:0];
  assign in_cmd.ct    = in_tdata[5:4];
  assign in_cmd.vals  = in_tdata[165:6];
  assign in_cmd.vmask = in_tdata[170:166];
  assign in_cmd.flag  = in_tdata[171];

  assign accept = in_tvalid && in_tready;

  assign ct_ext = 16'(cmd_r.ct);
  assign idx    = ct_ext[CIW-1:0];
  assign ct_ok  = 32'(cmd_r.ct) < CONTROL_TYPES;
  assign req_ok = 32'(cmd_r.req) < REQUESTERS;

  // overlay entry for the queried type, shared by all cells
  assign ovl.present = ct_ok && ovl_present_r[idx];
  assign ovl.flag    = cmd_r.flag;
  assign ovl.req     = ovl_req_r;
  assign ovl.vals    = ovl_vals_r[idx];
  assign ovl.mask    = ovl_mask_r[idx];

  // row of cells, partial result starts empty at the head
  assign tok[0] = '0;

  for (genvar g = 0; g < REQUESTERS; g++) begin : g_cell
    plra_cell #(
      .R             (g),
      .CONTROL_TYPES (CONTROL_TYPES)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd_r),
      .wr_en       (wr_en),
      .ovl         (ovl),
      .tok_in      (tok[g]),
      .tok_out     (tok[g+1]),
      .any_present (any_vec[g]),
      .lock_req    (lock_vec[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = (cmd_r.mode == MODE_QUERY) ? ST_WALK : ST_FIN;
      end
      ST_WALK: begin
        if (cnt_r == CW'(REQUESTERS - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    wr_en     = 1'b0;
    fin_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EXEC: wr_en     = 1'b1;
      ST_WALK: ;
      ST_FIN:  fin_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_WALK) cnt_r <= cnt_r + CW'(1);
      else                    cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cmd_r <= in_cmd;
    // lock state before the write, for the changed flag
    if (wr_en) lock_before_r <= |lock_vec;
  end

  // overlay control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_present_r <= '0;
      ovl_req_r     <= '0;
    end else if (wr_en) begin
      if (cmd_r.mode == MODE_STAGE && req_ok && ct_ok) begin
        ovl_present_r[idx] <= 1'b1;
        ovl_req_r          <= cmd_r.req;
      end else if (cmd_r.mode == MODE_CLEAR) begin
        ovl_present_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && cmd_r.mode == MODE_STAGE && req_ok && ct_ok) begin
      ovl_vals_r[idx] <= cmd_r.vals;
      ovl_mask_r[idx] <= cmd_r.vmask;
    end
  end

  // finish: for a query that found an entry, fill unset limits from the query word's values, clamp min to max
  always_comb begin
    res          = '0;
    res_mask     = '0;
    type_present = 1'b0;
    if (cmd_r.mode == MODE_QUERY && tok[REQUESTERS].present) begin
      type_present = 1'b1;
      res          = tok[REQUESTERS].vals;
      res_mask     = tok[REQUESTERS].mask;
      for (int i = 0; i < NUM_LIMITS; i++) begin
        if (!res_mask[i] && cmd_r.vmask[i]) begin
          res[i]      = cmd_r.vals[i];
          res_mask[i] = 1'b1;
        end
      end
      if (res_mask[LIM_MAX_POWER] && res_mask[LIM_MIN_POWER] &&
          res[LIM_MAX_POWER] < res[LIM_MIN_POWER]) begin
        res[LIM_MIN_POWER] = res[LIM_MAX_POWER];
      end
      if (res_mask[LIM_MAX_WINDOW] && res_mask[LIM_MIN_WINDOW] &&
          res[LIM_MAX_WINDOW] < res[LIM_MIN_WINDOW]) begin
        res[LIM_MIN_WINDOW] = res[LIM_MAX_WINDOW];
      end
    end
  end

  assign lock_changed = (cmd_r.mode == MODE_LOCK) && req_ok &&
                        (lock_before_r != |lock_vec);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fin_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_tdata_r <= {7'd0, lock_changed, |lock_vec, |any_vec, type_present,
                      res_mask, res};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // no word taken while one is in flight
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input accepted while busy");

  // a result is never overwritten before it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tvalid_r && $stable(out_tdata_r)))
    else $error("pending result lost");

  // a query result for an absent type carries no valid limit
  a_absent_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tdata_r[165]) |-> (out_tdata_r[164:160] == '0))
    else $error("valid limit without any entry");

endmodule
